// ===== rtl/core/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg: quaternion to rotation matrix shared types
// Widths and stage records for the normalize-and-divide pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package qrm_pkg;

  localparam int unsigned CompW  = 16;               // quaternion component
  localparam int unsigned ProdW  = 32;               // product of two components
  localparam int unsigned NormW  = 33;               // n = sum of four squares
  localparam int unsigned NumW   = 34;               // signed numerator
  localparam int unsigned DivW   = NormW + 1;        // divisor 2n
  localparam int unsigned QW     = 15;               // quotient, 0..16384
  localparam int unsigned RemW   = NormW + QW + 1;   // mag*2^15 + n
  localparam int unsigned NEnt   = 9;                // matrix entries
  localparam int unsigned EntW   = 16;               // Q1.14 entry
  localparam logic [EntW-1:0] OneQ14 = 16'd16384;

  // products of the components
  typedef struct packed {
    logic signed [ProdW-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;
  } prod_t;

  // norm and the nine numerators
  typedef struct packed {
    logic [NormW-1:0]                 n;
    logic [NEnt-1:0][NumW-1:0]        num;
  } sum_t;

  // one step of the restoring divider for all nine lanes
  typedef struct packed {
    logic [NEnt-1:0][RemW-1:0] rem;
    logic [NEnt-1:0][QW-1:0]   q;
    logic [NEnt-1:0]           neg;
    logic [DivW-1:0]           d;
    logic                      zero;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_to_rotation_matrix.sv =====
// Throughput: one item per cycle while m_tready is high; the 15 quotient bits are produced one per
// register stage by a restoring divider, nine lanes side by side.
// Each stage holds when its successor is full and stalled, so bubbles close up.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalizes a 16-bit quaternion and gives the 3x3 rotation matrix in Q1.14,
// rounded to nearest, ties away from zero. Zero quaternion gives identity.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // q_w, q_x, q_y, q_z
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,   // m_r0_c0 .. m_r2_c2, row-major
  output logic              m_tuser    // zero_quat
);

  localparam int unsigned NStg = 4 + QW + 1;
  localparam int unsigned OutS = NStg - 1;

  logic [NStg-1:0] vld;
  logic [NStg-1:0] ce;

  // stall chain: a stage loads when empty or when its successor moves
  always_comb begin
    ce[OutS] = !vld[OutS] || m_tready;
    for (int i = OutS - 1; i >= 0; i--) begin
      ce[i] = !vld[i] || ce[i+1];
    end
  end

  assign s_tready = ce[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NStg; i++) begin
        if (ce[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: input register
  logic signed [CompW-1:0] qw, qx, qy, qz;
  always_ff @(posedge clk) begin
    if (ce[0]) begin
      qw <= s_tdata[15:0];
      qx <= s_tdata[31:16];
      qy <= s_tdata[47:32];
      qz <= s_tdata[63:48];
    end
  end

  // stage 1: products
  prod_t prod;
  always_ff @(posedge clk) begin
    if (ce[1]) begin
      prod.ww <= qw * qw;
      prod.xx <= qx * qx;
      prod.yy <= qy * qy;
      prod.zz <= qz * qz;
      prod.xy <= qx * qy;
      prod.zw <= qz * qw;
      prod.xz <= qx * qz;
      prod.yw <= qy * qw;
      prod.yz <= qy * qz;
      prod.xw <= qx * qw;
    end
  end

  // stage 2: norm and numerators
  sum_t sums, sums_next;
  always_comb begin
    logic signed [NumW-1:0] ww, xx, yy, zz;
    ww = NumW'(prod.ww);
    xx = NumW'(prod.xx);
    yy = NumW'(prod.yy);
    zz = NumW'(prod.zz);
    sums_next.n      = NormW'(ww + xx + yy + zz);
    sums_next.num[0] = ww + xx - yy - zz;
    sums_next.num[1] = (NumW'(prod.xy) - NumW'(prod.zw)) <<< 1;
    sums_next.num[2] = (NumW'(prod.xz) + NumW'(prod.yw)) <<< 1;
    sums_next.num[3] = (NumW'(prod.xy) + NumW'(prod.zw)) <<< 1;
    sums_next.num[4] = ww - xx + yy - zz;
    sums_next.num[5] = (NumW'(prod.yz) - NumW'(prod.xw)) <<< 1;
    sums_next.num[6] = (NumW'(prod.xz) - NumW'(prod.yw)) <<< 1;
    sums_next.num[7] = (NumW'(prod.yz) + NumW'(prod.xw)) <<< 1;
    sums_next.num[8] = ww - xx - yy + zz;
  end

  always_ff @(posedge clk) begin
    if (ce[2]) sums <= sums_next;
  end

  // stage 3: magnitudes, rounding offset, divisor
  div_t dst [QW+1];
  div_t dinit;
  always_comb begin
    logic [NumW-1:0] mag;
    dinit.d    = {sums.n, 1'b0};
    dinit.zero = (sums.n == '0);
    for (int k = 0; k < NEnt; k++) begin
      dinit.neg[k] = sums.num[k][NumW-1];
      mag = dinit.neg[k] ? NumW'(-sums.num[k]) : sums.num[k];
      dinit.rem[k] = {1'b0, mag[NormW-1:0], {QW{1'b0}}} + RemW'(sums.n);
      dinit.q[k]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce[3]) dst[0] <= dinit;
  end

  // stages 4..18: one quotient bit per stage, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned Bit = QW - 1 - j;
    div_t nxt;
    always_comb begin
      logic [RemW-1:0] sh;
      nxt = dst[j];
      sh  = RemW'(dst[j].d) << Bit;
      for (int k = 0; k < NEnt; k++) begin
        if (dst[j].rem[k] >= sh) begin
          nxt.rem[k]   = dst[j].rem[k] - sh;
          nxt.q[k][Bit] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce[4+j]) dst[j+1] <= nxt;
    end
  end

  // output stage: sign, identity on zero quaternion
  logic [143:0] mat_next;
  always_comb begin
    logic [EntW-1:0] qe;
    for (int k = 0; k < NEnt; k++) begin
      qe = EntW'(dst[QW].q[k]);
      if (dst[QW].zero) begin
        mat_next[k*EntW +: EntW] = (k == 0 || k == 4 || k == 8) ? OneQ14 : '0;
      end else begin
        mat_next[k*EntW +: EntW] = dst[QW].neg[k] ? EntW'(-qe) : qe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[OutS]) begin
      m_tdata <= mat_next;
      m_tuser <= dst[QW].zero;
    end
  end

  assign m_tvalid = vld[OutS];

`ifndef ASSERT_OFF
  // zero quaternion gives the identity diagonal
  a_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == OneQ14 && m_tdata[79:64] == OneQ14
      && m_tdata[143:128] == OneQ14)
    else $error("identity not given for zero quaternion");

  // the first two entries stay within one in magnitude
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) >= -16384 && $signed(m_tdata[15:0]) <= 16384
      && $signed(m_tdata[31:16]) >= -16384 && $signed(m_tdata[31:16]) <= 16384)
    else $error("matrix entry out of range");

  // pipeline empty after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
